FILE: sv/b85g_pkg.sv
// b85g_pkg: constants and types shared by the base-85 group encoder modules
// no dependencies
`default_nettype none

package b85g_pkg;

	localparam int unsigned ByteBits   = 8;
	localparam int unsigned GroupBits  = 32;
	localparam int unsigned CharBits   = 7;
	localparam int unsigned CharsPerGrp = 5;
	localparam int unsigned QueueDepth = 2;

	// floor(v / 85) == (v * Recip85) >> RecipShift for every 32-bit v
	localparam logic [31:0] Recip85    = 32'd3233857729;
	localparam int unsigned RecipShift = 38;

	localparam logic [CharBits-1:0] Radix  = 7'd85;
	localparam logic [CharBits-1:0] Offset = 7'd33;

	// index of the final character of a group
	localparam logic [2:0] LastCharIdx = 3'd4;

	// fill level of the open group, before the new byte
	typedef enum logic [1:0] {
		HELD_0 = 2'd0,
		HELD_1 = 2'd1,
		HELD_2 = 2'd2,
		HELD_3 = 2'd3
	} held_t;

	// one closed group on its way from the front to the back
	typedef struct packed {
		logic [GroupBits-1:0] value;
		logic                 last;
	} group_t;

	// queue status seen by its neighbors
	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_stat_t;

endpackage

`default_nettype wire

FILE: sv/b85g_front.sv
// b85g_front: takes bytes, packs them big-endian and closes padded groups
// depends on b85g_pkg
`default_nettype none

module b85g_front
	import b85g_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire queue_stat_t q_stat,
	output logic             push,
	output group_t           push_group
);

	logic [23:0] group_word_q;
	held_t       bytes_held_q;
	logic        accept;
	logic        closes;
	logic [31:0] padded;

	assign byte_ready = !q_stat.full;
	assign accept     = byte_valid && byte_ready;
	assign closes     = last_byte || (bytes_held_q == HELD_3);

	// new byte goes in after the held ones, zero bytes fill the rest
	always_comb begin
		unique case (bytes_held_q)
			HELD_0: padded = {data_byte, 24'd0};
			HELD_1: padded = {group_word_q[7:0], data_byte, 16'd0};
			HELD_2: padded = {group_word_q[15:0], data_byte, 8'd0};
			HELD_3: padded = {group_word_q[23:0], data_byte};
			default: padded = '0;
		endcase
	end

	assign push             = accept && closes;
	assign push_group.value = padded;
	assign push_group.last  = last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_word_q <= '0;
			bytes_held_q <= HELD_0;
		end else if (accept) begin
			if (closes) begin
				group_word_q <= '0;
				bytes_held_q <= HELD_0;
			end else begin
				group_word_q <= {group_word_q[15:0], data_byte};
				bytes_held_q <= held_t'(bytes_held_q + 2'd1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/b85g_queue.sv
// b85g_queue: short group queue between the front and the back
// depends on b85g_pkg
`default_nettype none

module b85g_queue
	import b85g_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire group_t push_group,
	input  wire logic   pop,
	output group_t      head,
	output queue_stat_t stat
);

	localparam int unsigned PtrBits = $clog2(QueueDepth);

	group_t               mem_q [QueueDepth];
	logic [PtrBits-1:0]   wr_ptr_q;
	logic [PtrBits-1:0]   rd_ptr_q;
	logic [PtrBits:0]     count_q;

	assign stat.full      = (count_q == (PtrBits+1)'(QueueDepth));
	assign stat.not_empty = (count_q != '0);
	assign head           = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/b85g_back.sv
// b85g_back: turns queued groups into five base-85 characters, low digit first
// depends on b85g_pkg
`default_nettype none

module b85g_back
	import b85g_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire queue_stat_t q_stat,
	input  wire group_t      head,
	output logic             pop,
	output logic             char_valid,
	input  wire logic        char_ready,
	output logic [6:0]       code_char,
	output logic             last_char
);

	logic        busy_q;
	logic [2:0]  cnt_q;
	logic [31:0] div_q;
	logic        last_q;

	logic        valid_s1;
	logic [6:0]  rem_s1;
	logic [6:0]  quo_s1;
	logic        last_s1;

	logic        out_valid_q;
	logic [6:0]  out_char_q;
	logic        out_last_q;

	logic        out_take;
	logic        s1_take;
	logic        gen_fire;
	logic        gen_done;
	logic [63:0] prod;
	logic [31:0] quo;
	logic [6:0]  digit;

	assign out_take = !out_valid_q || char_ready;
	assign s1_take  = !valid_s1 || out_take;
	assign gen_fire = busy_q && s1_take;
	assign gen_done = gen_fire && (cnt_q == LastCharIdx);
	assign pop      = q_stat.not_empty && (!busy_q || gen_done);

	// divide by 85 through the reciprocal, quotient fits in 26 bits
	assign prod = 64'(div_q) * 64'(Recip85);
	assign quo  = 32'(prod[63:RecipShift]);

	// remainder is below 85, so the low seven bits are enough
	assign digit = rem_s1 - 7'(quo_s1 * Radix);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (gen_fire) begin
			busy_q <= !gen_done;
			cnt_q  <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			div_q  <= head.value;
			last_q <= head.last;
		end else if (gen_fire) begin
			div_q <= quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_take) begin
				valid_s1 <= gen_fire;
			end
			if (out_take) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gen_fire) begin
			rem_s1  <= div_q[6:0];
			quo_s1  <= quo[6:0];
			last_s1 <= last_q && (cnt_q == LastCharIdx);
		end
		if (out_take && valid_s1) begin
			out_char_q <= digit + Offset;
			out_last_q <= last_s1;
		end
	end

	assign char_valid = out_valid_q;
	assign code_char  = out_char_q;
	assign last_char  = out_last_q;

endmodule

`default_nettype wire

FILE: sv/base85_group_encoder_core.sv
// base85_group_encoder_core: byte stream in, base-85 characters out
// depends on b85g_pkg, b85g_front, b85g_queue, b85g_back
//
//   channel | handshake               | beat payload
//   --------+-------------------------+-----------------------
//   byte    | byte_valid / byte_ready | data_byte, last_byte
//   char    | char_valid / char_ready | code_char, last_char
//
// one byte per cycle while the two-group queue has room
// the back emits one character per cycle while char_ready allows,
// five per group of four bytes
// first character of a group leaves after its closing byte passes through
// (queue, divider register, divide stage, output register)
// a stall on the char side fills the queue, then drops byte_ready
// reset clears the open group and all valid flags, no clearing pass
`default_nettype none

module base85_group_encoder_core
	import b85g_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output logic            char_valid,
	input  wire logic       char_ready,
	output logic [6:0]      code_char,
	output logic            last_char
);

	queue_stat_t q_stat;
	logic        push;
	group_t      push_group;
	logic        pop;
	group_t      head;

	b85g_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.q_stat     (q_stat),
		.push       (push),
		.push_group (push_group)
	);

	b85g_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	b85g_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head       (head),
		.pop        (pop),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.code_char  (code_char),
		.last_char  (last_char)
	);

endmodule

`default_nettype wire

FILE: sv/b85g_checker.sv
// b85g_checker: port-level checks for base85_group_encoder_core, bound to it
// depends on b85g_pkg
`default_nettype none

module b85g_checker
	import b85g_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       byte_valid,
	input wire logic       byte_ready,
	input wire logic [7:0] data_byte,
	input wire logic       last_byte,
	input wire logic       char_valid,
	input wire logic       char_ready,
	input wire logic [6:0] code_char,
	input wire logic       last_char
);

	logic [2:0] pos_q;
	logic       char_beat;

	assign char_beat = char_valid && char_ready;

	// place of the next char beat inside its group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (char_beat) begin
			pos_q <= (pos_q == LastCharIdx) ? 3'd0 : pos_q + 3'd1;
		end
	end

	a_char_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_ready |=> char_valid && $stable(code_char)
			&& $stable(last_char))
		else $error("char beat changed while stalled");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (code_char >= Offset) && (code_char <= Offset + Radix - 7'd1))
		else $error("code_char out of range");

	a_last_place: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && last_char |-> pos_q == LastCharIdx)
		else $error("last_char off the fifth char of a group");

	a_no_early_char: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !char_valid)
		else $error("char beat right after reset");

	// a byte beat waiting on a full queue stays put
	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid && $stable(data_byte)
			&& $stable(last_byte))
		else $error("byte beat changed while stalled");

endmodule

bind base85_group_encoder_core b85g_checker u_b85g_checker (.*);

`default_nettype wire

FILE: test/base85_group_encoder_core_tb.sv
// base85_group_encoder_core_tb: self-checking bench for the base-85 group encoder
// depends on b85g_pkg and base85_group_encoder_core; a typed stimulus table, then
// random messages, characters checked against a behavioral group encoder or table
`timescale 1ns / 1ps

module base85_group_encoder_core_tb
	import b85g_pkg::*;
;

	localparam int unsigned CycleLimit = 100000;
	localparam int unsigned RandBytes  = 80;
	localparam int unsigned CalmBytes  = 25;
	localparam int unsigned DrainCycles = 20;

	// five characters of a group, least significant digit in the low bits
	localparam logic [34:0] CharsZero = {7'd33, 7'd33, 7'd33, 7'd33, 7'd33};
	localparam logic [34:0] CharsOnes = {7'd115, 7'd56, 7'd87, 7'd45, 7'd33};

	typedef struct packed {
		logic [6:0] ch;
		logic       lst;
	} char_beat_t;

	typedef struct packed {
		logic [7:0]  b;
		logic        l;
		logic        fixed;
		logic [34:0] chars;
	} byte_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_ready;
	logic [7:0] data_byte = 8'd0;
	logic       last_byte = 1'b0;
	logic       char_valid;
	logic       char_ready = 1'b0;
	logic [6:0] code_char;
	logic       last_char;

	// behavioral copy of the open group
	logic [31:0] open_group = '0;
	held_t       open_count = HELD_0;

	char_beat_t  pending_chars[$];
	byte_row_t   stim_table[$];

	bit          idle_on = 1'b1;
	int unsigned mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned chars_seen = 0;
	int unsigned marked_groups = 0;
	int unsigned cycles = 0;

	base85_group_encoder_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.code_char  (code_char),
		.last_char  (last_char)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d characters still due",
				cycles, pending_chars.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// shift in one byte; close the group on the fourth byte or a last mark
	task automatic encode_byte(input logic [7:0] b, input logic l,
			output bit closed, output logic [34:0] chars);
		logic [31:0] v;
		int unsigned cnt;
		open_group = {open_group[23:0], b};
		cnt = int'(open_count) + 1;
		closed = 1'b0;
		chars = '0;
		if (cnt < 4 && !l) begin
			open_count = held_t'(cnt[1:0]);
		end else begin
			v = open_group << (ByteBits * (4 - cnt));
			for (int k = 0; k < CharsPerGrp; k++) begin
				chars[7*k +: 7] = 7'(v % Radix) + Offset;
				v = v / Radix;
			end
			closed = 1'b1;
			open_group = '0;
			open_count = HELD_0;
		end
	endtask

	task automatic add_row(input logic [7:0] b, input logic l, input logic fixed,
			input logic [34:0] chars);
		stim_table.push_back('{b: b, l: l, fixed: fixed, chars: chars});
	endtask

	// present one byte beat, hold it until taken, then queue what it produces
	task automatic send_byte(input byte_row_t row);
		int unsigned gap;
		bit closed;
		logic [34:0] chars;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= row.b;
		last_byte <= row.l;
		do @(posedge clk); while (!byte_ready);
		bytes_sent++;
		encode_byte(row.b, row.l, closed, chars);
		if (closed) begin
			if (row.fixed)
				chars = row.chars;
			if (row.l)
				marked_groups++;
			for (int k = 0; k < CharsPerGrp; k++)
				pending_chars.push_back('{ch: chars[7*k +: 7],
					lst: row.l && (k == LastCharIdx)});
		end
	endtask

	// char side: compare each beat, then pick ready for the next cycle
	initial begin
		int unsigned stall_left;
		char_beat_t want;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && char_valid && char_ready) begin
				chars_seen++;
				if (pending_chars.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected char %0d last %0b", code_char, last_char);
				end else begin
					want = pending_chars.pop_front();
					if (code_char !== want.ch || last_char !== want.lst) begin
						mismatches++;
						if (mismatches <= 10)
							$display("char %0d: expected %0d last %0b, got %0d last %0b",
								chars_seen, want.ch, want.lst, code_char, last_char);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				char_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				char_ready <= 1'b0;
			end else begin
				char_ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned msg_len;
		int unsigned rand_sent;
		int unsigned directed;
		logic l;
		// zero group with last mark
		add_row(8'h00, 1'b1, 1'b1, CharsZero);
		// full group of ones, unmarked
		add_row(8'hFF, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b1, CharsOnes);
		// full group whose fourth byte carries the last mark
		add_row(8'hFF, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b1, 1'b1, CharsOnes);
		// short final groups, padded with zero bytes
		add_row(8'h80, 1'b0, 1'b0, '0);
		add_row(8'h01, 1'b1, 1'b0, '0);
		add_row(8'h55, 1'b1, 1'b0, '0);
		add_row(8'h01, 1'b0, 1'b0, '0);
		add_row(8'h02, 1'b0, 1'b0, '0);
		add_row(8'h03, 1'b1, 1'b0, '0);
		// zero group closed by count alone
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b1, CharsZero);
		add_row(8'hA5, 1'b0, 1'b0, '0);
		add_row(8'h5A, 1'b1, 1'b0, '0);
		directed = stim_table.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i])
			send_byte(stim_table[i]);

		// random messages of 1 to 9 bytes, a few left without a last mark
		rand_sent = 0;
		while (rand_sent < RandBytes) begin
			msg_len = $urandom_range(1, 9);
			for (int i = 0; i < msg_len; i++) begin
				if (rand_sent >= RandBytes - CalmBytes)
					idle_on = 1'b0;
				l = (i == msg_len - 1) && ($urandom_range(0, 7) != 0);
				send_byte('{b: 8'($urandom), l: l, fixed: 1'b0, chars: '0});
				rand_sent++;
			end
		end
		// flush whatever group is still open
		send_byte('{b: 8'($urandom), l: 1'b1, fixed: 1'b0, chars: '0});
		byte_valid <= 1'b0;

		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("sent %0d bytes (%0d from the table), checked %0d characters",
			bytes_sent, directed, chars_seen);
		$display("%0d groups closed by a last mark, %0d mismatches",
			marked_groups, mismatches);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/b85g_pkg.sv
sv/b85g_front.sv
sv/b85g_queue.sv
sv/b85g_back.sv
sv/base85_group_encoder_core.sv
sv/b85g_checker.sv
test/base85_group_encoder_core_tb.sv
